### rtl/core/tcdc_pkg.sv
package tcdc_pkg;

	localparam int COORD_BITS = 16;
	localparam int ID_BITS    = 16;
	localparam int GRID_BITS  = 5;
	localparam int DWELL_BITS = 16;
	localparam int INDEX_BITS = 8;
	localparam int COUNT_BITS = 8;
	localparam int CFG_ADDR_BITS = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_ADDR_BITS-1:0] REG_GRID_COLUMNS = 2'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_GRID_ROWS    = 2'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_DWELL_FRAMES = 2'd2;

	localparam logic CMD_FRAME   = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	localparam logic [GRID_BITS-1:0]  GRID_MIN       = 5'd2;
	localparam logic [GRID_BITS-1:0]  GRID_MAX       = 5'd16;
	localparam logic [GRID_BITS-1:0]  GRID_RESET     = 5'd3;
	localparam logic [DWELL_BITS-1:0] DWELL_RESET    = 16'd50;
	localparam logic [DWELL_BITS-1:0] DWELL_SAT      = '1;

	typedef struct packed {
		logic [GRID_BITS-1:0]  grid_columns;
		logic [GRID_BITS-1:0]  grid_rows;
		logic [DWELL_BITS-1:0] dwell_frames;
	} tcdc_cfg_t;

	typedef struct packed {
		logic                  cmd;
		logic [COUNT_BITS-1:0] blob_count;
		logic [ID_BITS-1:0]    touch_id;
		logic [COORD_BITS-1:0] touch_x;
		logic [COORD_BITS-1:0] touch_y;
	} tcdc_item_t;

	typedef struct packed {
		logic                  captured;
		logic [INDEX_BITS-1:0] point_index;
		logic [COORD_BITS-1:0] point_x;
		logic [COORD_BITS-1:0] point_y;
		logic                  complete;
		logic                  capturing;
	} tcdc_result_t;

	typedef struct packed {
		logic                  capture_active;
		logic                  calibration_done;
		logic [INDEX_BITS-1:0] active_index;
		logic [ID_BITS-1:0]    previous_id;
		logic                  previous_id_valid;
		logic [ID_BITS-1:0]    finished_id;
		logic                  finished_id_valid;
		logic [DWELL_BITS-1:0] dwell_count;
		logic [COORD_BITS-1:0] average_x;
		logic [COORD_BITS-1:0] average_y;
	} tcdc_state_t;

	function automatic logic [GRID_BITS-1:0] clamp_grid(input logic [GRID_BITS-1:0] v);
		if (v < GRID_MIN) begin
			return GRID_MIN;
		end else if (v > GRID_MAX) begin
			return GRID_MAX;
		end
		return v;
	endfunction

	function automatic logic [COORD_BITS-1:0] halve_sum(input logic [COORD_BITS-1:0] a,
			input logic [COORD_BITS-1:0] b);
		logic [COORD_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[COORD_BITS:1];
	endfunction

endpackage

### rtl/core/tcdc_in_if.sv
interface tcdc_in_if import tcdc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [COUNT_BITS-1:0] blob_count;
	logic [ID_BITS-1:0]    touch_id;
	logic [COORD_BITS-1:0] touch_x;
	logic [COORD_BITS-1:0] touch_y;

	modport source(output valid, cmd, blob_count, touch_id, touch_x, touch_y, input ready);
	modport sink(input valid, cmd, blob_count, touch_id, touch_x, touch_y, output ready);
endinterface

### rtl/core/tcdc_out_if.sv
interface tcdc_out_if import tcdc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  captured;
	logic [INDEX_BITS-1:0] point_index;
	logic [COORD_BITS-1:0] point_x;
	logic [COORD_BITS-1:0] point_y;
	logic                  complete;
	logic                  capturing;

	modport source(output valid, captured, point_index, point_x, point_y, complete, capturing,
		input ready);
	modport sink(input valid, captured, point_index, point_x, point_y, complete, capturing,
		output ready);
endinterface

### rtl/core/tcdc_cfg_if.sv
interface tcdc_cfg_if import tcdc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CFG_ADDR_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### rtl/core/touch_calibration_dwell_capture_unit.sv
// Accepted frames pass through the input register, then the result register, to the result
// channel. Throughput: one frame per cycle unless result.ready stalls the result register;
// the single update stage between them reads and writes capture state in the same cycle.
// Reset (arst_n low, asynchronous): capture idle, not complete, grid index 0, no tracked
// or finished id, dwell count and averages 0, registers 3 x 3 grid with dwell 50.
module touch_calibration_dwell_capture_unit import tcdc_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	tcdc_in_if.sink     frame,
	tcdc_out_if.source  result,
	tcdc_cfg_if.sink    cfg
);

	tcdc_cfg_t    cfg_q;
	tcdc_state_t  st_q;
	tcdc_state_t  st_next;
	tcdc_item_t   item_s1;
	logic         valid_s1;
	tcdc_result_t res_next;
	tcdc_result_t res_s2;
	logic         valid_s2;
	logic         advance;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_columns <= GRID_RESET;
			cfg_q.grid_rows    <= GRID_RESET;
			cfg_q.dwell_frames <= DWELL_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_GRID_COLUMNS: cfg_q.grid_columns <= cfg.data[GRID_BITS-1:0];
				REG_GRID_ROWS:    cfg_q.grid_rows    <= cfg.data[GRID_BITS-1:0];
				REG_DWELL_FRAMES: cfg_q.dwell_frames <= cfg.data[DWELL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 moves into the result register when that register is free or being drained
	assign advance     = valid_s1 && (!valid_s2 || result.ready);
	assign frame.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			item_s1.cmd        <= frame.cmd;
			item_s1.blob_count <= frame.blob_count;
			item_s1.touch_id   <= frame.touch_id;
			item_s1.touch_x    <= frame.touch_x;
			item_s1.touch_y    <= frame.touch_y;
		end
	end

	tcdc_step u_step (
		.cfg     (cfg_q),
		.st      (st_q),
		.item    (item_s1),
		.st_next (st_next),
		.res     (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				st_q <= st_next;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign result.valid       = valid_s2;
	assign result.captured    = res_s2.captured;
	assign result.point_index = res_s2.point_index;
	assign result.point_x     = res_s2.point_x;
	assign result.point_y     = res_s2.point_y;
	assign result.complete    = res_s2.complete;
	assign result.capturing   = res_s2.capturing;

	// capture only ends on the final grid point, which marks calibration done
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(st_q.capture_active) |-> st_q.calibration_done)
		else $error("capture ended without completing calibration");

	// dwell count moves only on frames taken while capturing
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.dwell_count != $past(st_q.dwell_count)) |-> $past(st_q.capture_active))
		else $error("dwell count changed outside capture");

	// first finished id comes with a captured result loaded at the same edge
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q.finished_id_valid) |-> (valid_s2 && res_s2.captured))
		else $error("finished id set without a captured point");

endmodule

### rtl/core/tcdc_step.sv
module tcdc_step import tcdc_pkg::*; (
	input  tcdc_cfg_t    cfg,
	input  tcdc_state_t  st,
	input  tcdc_item_t   item,
	output tcdc_state_t  st_next,
	output tcdc_result_t res
);

	logic [DWELL_BITS-1:0]   need;
	logic [2*GRID_BITS-1:0]  grid_size;
	logic [INDEX_BITS-1:0]   final_point;
	logic                    repeat_id;
	logic                    ignore;
	logic [DWELL_BITS-1:0]   cnt;

	always_comb begin
		need        = (cfg.dwell_frames == '0) ? DWELL_BITS'(1) : cfg.dwell_frames;
		grid_size   = {{GRID_BITS{1'b0}}, clamp_grid(cfg.grid_columns)}
			* {{GRID_BITS{1'b0}}, clamp_grid(cfg.grid_rows)};
		final_point = INDEX_BITS'(grid_size - 1'b1);
		repeat_id   = st.previous_id_valid && (item.touch_id == st.previous_id);
		ignore      = repeat_id && st.finished_id_valid && (st.finished_id == item.touch_id);
		cnt         = st.dwell_count;
		st_next     = st;
		res         = '0;

		if (item.cmd == CMD_RESTART) begin
			st_next.capture_active    = 1'b1;
			st_next.active_index      = '0;
			st_next.previous_id_valid = 1'b0;
		end else if (st.capture_active && item.blob_count == COUNT_BITS'(1)) begin
			if (repeat_id && !ignore) begin
				if (st.dwell_count == '0) begin
					st_next.average_x = item.touch_x;
					st_next.average_y = item.touch_y;
				end else begin
					st_next.average_x = halve_sum(st.average_x, item.touch_x);
					st_next.average_y = halve_sum(st.average_y, item.touch_y);
				end
				if (cnt != DWELL_SAT) begin
					cnt = cnt + 1'b1;
				end
			end else if (!repeat_id) begin
				cnt = '0;
			end
			if (!ignore) begin
				st_next.previous_id       = item.touch_id;
				st_next.previous_id_valid = 1'b1;
				st_next.dwell_count       = cnt;
				if (cnt >= need) begin
					st_next.finished_id       = item.touch_id;
					st_next.finished_id_valid = 1'b1;
					st_next.dwell_count       = '0;
					res.captured    = 1'b1;
					res.point_index = st.active_index;
					res.point_x     = st_next.average_x;
					res.point_y     = st_next.average_y;
					// last grid point (or past it) closes the run
					if (st.active_index >= final_point) begin
						st_next.active_index     = '0;
						st_next.capture_active   = 1'b0;
						st_next.calibration_done = 1'b1;
					end else begin
						st_next.active_index = st.active_index + 1'b1;
					end
				end
			end
		end

		res.complete  = st_next.calibration_done;
		res.capturing = st_next.capture_active;
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import tcdc_pkg::*;

	localparam int STALL_LIMIT = 4000;

	typedef struct {
		bit           typed;
		tcdc_result_t reply;
	} reply_hint_t;

	typedef struct {
		tcdc_item_t   frame;
		bit           typed;
		tcdc_result_t reply;
	} opening_row_t;

	logic clk = 1'b0;
	logic arst_n;

	tcdc_in_if  frame_if ();
	tcdc_out_if result_if ();
	tcdc_cfg_if cfg_if ();

	touch_calibration_dwell_capture_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the block: grid registers and capture state.
	tcdc_cfg_t    regs;
	tcdc_state_t  cal;
	tcdc_result_t calib_reports[$];
	reply_hint_t  reply_hints[$];

	int          mismatches = 0;
	int unsigned frames_sent = 0;
	int unsigned send_idle_pct = 21;
	int unsigned recv_idle_pct = 81;
	logic [ID_BITS-1:0] last_run_id = '0;
	logic [ID_BITS-1:0] run_ids[8] = '{16'h0000, 16'hffff, 16'h0001, 16'h8000,
		16'h7fff, 16'h1234, 16'h00ff, 16'hff00};

	function automatic tcdc_result_t calib_step(input tcdc_item_t f);
		tcdc_result_t r;
		logic skip;
		logic [DWELL_BITS-1:0] need;
		logic [GRID_BITS-1:0] c, rw;
		int last;
		r = '0;
		skip = 1'b0;
		if (f.cmd == CMD_RESTART) begin
			cal.capture_active = 1'b1;
			cal.active_index = '0;
			cal.previous_id_valid = 1'b0;
		end else if (cal.capture_active && f.blob_count == 8'd1) begin
			if (cal.previous_id_valid && f.touch_id == cal.previous_id) begin
				if (cal.finished_id_valid && cal.finished_id == f.touch_id) begin
					skip = 1'b1;
				end else begin
					if (cal.dwell_count == 0) begin
						cal.average_x = f.touch_x;
						cal.average_y = f.touch_y;
					end else begin
						cal.average_x = COORD_BITS'(({1'b0, cal.average_x} + {1'b0, f.touch_x}) >> 1);
						cal.average_y = COORD_BITS'(({1'b0, cal.average_y} + {1'b0, f.touch_y}) >> 1);
					end
					if (cal.dwell_count != DWELL_SAT)
						cal.dwell_count++;
				end
			end else begin
				cal.dwell_count = '0;
			end
			if (!skip) begin
				need = (regs.dwell_frames == 0) ? 16'd1 : regs.dwell_frames;
				cal.previous_id = f.touch_id;
				cal.previous_id_valid = 1'b1;
				if (cal.dwell_count >= need) begin
					c = (regs.grid_columns < GRID_MIN) ? GRID_MIN :
						(regs.grid_columns > GRID_MAX) ? GRID_MAX : regs.grid_columns;
					rw = (regs.grid_rows < GRID_MIN) ? GRID_MIN :
						(regs.grid_rows > GRID_MAX) ? GRID_MAX : regs.grid_rows;
					last = int'(c) * int'(rw) - 1;
					cal.finished_id = f.touch_id;
					cal.finished_id_valid = 1'b1;
					r.captured = 1'b1;
					r.point_index = cal.active_index;
					r.point_x = cal.average_x;
					r.point_y = cal.average_y;
					cal.dwell_count = '0;
					if (cal.active_index >= last) begin
						cal.active_index = '0;
						cal.capture_active = 1'b0;
						cal.calibration_done = 1'b1;
					end else begin
						cal.active_index++;
					end
				end
			end
		end
		r.complete = cal.calibration_done;
		r.capturing = cal.capture_active;
		return r;
	endfunction

	function automatic tcdc_item_t make_frame(input int unsigned cmd, input int unsigned count,
			input int unsigned id, input int unsigned x, input int unsigned y);
		tcdc_item_t f;
		f.cmd = 1'(cmd);
		f.blob_count = COUNT_BITS'(count);
		f.touch_id = ID_BITS'(id);
		f.touch_x = COORD_BITS'(x);
		f.touch_y = COORD_BITS'(y);
		return f;
	endfunction

	function automatic tcdc_result_t report(input int unsigned captured, input int unsigned idx,
			input int unsigned x, input int unsigned y,
			input int unsigned complete, input int unsigned capturing);
		tcdc_result_t r;
		r.captured = 1'(captured);
		r.point_index = INDEX_BITS'(idx);
		r.point_x = COORD_BITS'(x);
		r.point_y = COORD_BITS'(y);
		r.complete = 1'(complete);
		r.capturing = 1'(capturing);
		return r;
	endfunction

	function automatic logic [COORD_BITS-1:0] pick_coord();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	// Touch count other than one, zero now and then.
	function automatic logic [COUNT_BITS-1:0] crowd();
		logic [COUNT_BITS-1:0] n;
		n = COUNT_BITS'($urandom_range(255, 2));
		if ($urandom_range(3) == 0)
			n = '0;
		return n;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic drive_frame(input tcdc_item_t f, input bit typed, input tcdc_result_t reply);
		reply_hint_t hint;
		if (frames_sent < 675) begin
			send_idle_pct = 21;
			recv_idle_pct = 81;
		end else if (frames_sent < 1325) begin
			send_idle_pct = 81;
			recv_idle_pct = 21;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			frame_if.valid <= 1'b0;
			@(posedge clk);
		end
		hint.typed = typed;
		hint.reply = reply;
		reply_hints = {reply_hints, hint};
		frame_if.valid <= 1'b1;
		{frame_if.cmd, frame_if.blob_count, frame_if.touch_id, frame_if.touch_x,
			frame_if.touch_y} <= f;
		@(posedge clk);
		while (!frame_if.ready)
			@(posedge clk);
		frames_sent++;
	endtask

	task automatic settle();
		frame_if.valid <= 1'b0;
		while (calib_reports.size() != 0 || reply_hints.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(input int unsigned cols, input int unsigned rows,
			input int unsigned dwell);
		logic [CFG_ADDR_BITS-1:0] idx[3];
		logic [CFG_DATA_BITS-1:0] val[3];
		idx = '{REG_GRID_COLUMNS, REG_GRID_ROWS, REG_DWELL_FRAMES};
		val = '{CFG_DATA_BITS'(cols), CFG_DATA_BITS'(rows), CFG_DATA_BITS'(dwell)};
		for (int k = 0; k < 3; k++) begin
			cfg_if.valid <= 1'b1;
			cfg_if.index <= idx[k];
			cfg_if.data <= val[k];
			@(posedge clk);
			while (!cfg_if.ready)
				@(posedge clk);
		end
		cfg_if.valid <= 1'b0;
	endtask

	// One dwell attempt on a touch, or a restart, or a stray frame.
	task automatic feed_run(input bit tidy, input bit mid_restart);
		int unsigned roll, need, length;
		logic [ID_BITS-1:0] id;
		roll = $urandom_range(99);
		if ((!cal.capture_active && roll < 70) || (mid_restart && roll < 2)) begin
			drive_frame(make_frame(CMD_RESTART, COUNT_BITS'($urandom), ID_BITS'($urandom),
				pick_coord(), pick_coord()), 1'b0, '0);
			return;
		end
		if (!tidy && roll < 12) begin
			drive_frame(make_frame(CMD_FRAME, crowd(), ID_BITS'($urandom), pick_coord(),
				pick_coord()), 1'b0, '0);
			return;
		end
		if (!tidy && roll < 18) begin
			drive_frame(make_frame(CMD_FRAME, 8'd1, ID_BITS'($urandom), pick_coord(),
				pick_coord()), 1'b0, '0);
			return;
		end
		need = (regs.dwell_frames == 0) ? 1 : regs.dwell_frames;
		if (need > 10)
			need = 10;
		length = need + 1;
		if (tidy) begin
			last_run_id++;
			id = last_run_id;
		end else begin
			id = $urandom_range(1) ? run_ids[$urandom_range(7)] : ID_BITS'($urandom);
			length += $urandom_range(2);
			// cut some runs short of the dwell
			if ($urandom_range(5) == 0)
				length -= 2;
		end
		repeat (length) begin
			if (!tidy && $urandom_range(14) == 0)
				drive_frame(make_frame(CMD_FRAME, crowd(), ID_BITS'($urandom), pick_coord(),
					pick_coord()), 1'b0, '0);
			drive_frame(make_frame(CMD_FRAME, 8'd1, id, pick_coord(), pick_coord()), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin : observe
		tcdc_item_t seen;
		tcdc_result_t predicted;
		reply_hint_t hint;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.index)
					REG_GRID_COLUMNS: regs.grid_columns = cfg_if.data[GRID_BITS-1:0];
					REG_GRID_ROWS:    regs.grid_rows = cfg_if.data[GRID_BITS-1:0];
					REG_DWELL_FRAMES: regs.dwell_frames = cfg_if.data[DWELL_BITS-1:0];
					default: ;
				endcase
			end
			if (frame_if.valid && frame_if.ready) begin
				seen = {frame_if.cmd, frame_if.blob_count, frame_if.touch_id, frame_if.touch_x,
					frame_if.touch_y};
				predicted = calib_step(seen);
				hint = reply_hints.pop_front();
				calib_reports = {calib_reports, (hint.typed ? hint.reply : predicted)};
			end
		end
	end

	always @(posedge clk) begin : check_results
		tcdc_result_t want, got;
		if (arst_n && result_if.valid && result_if.ready) begin
			got = {result_if.captured, result_if.point_index, result_if.point_x,
				result_if.point_y, result_if.complete, result_if.capturing};
			if (calib_reports.size() == 0) begin
				$error("result transaction with nothing outstanding");
				mismatches++;
			end else begin
				want = calib_reports.pop_front();
				check_field("captured", want.captured, got.captured);
				check_field("point_index", want.point_index, got.point_index);
				check_field("point_x", want.point_x, got.point_x);
				check_field("point_y", want.point_y, got.point_y);
				check_field("complete", want.complete, got.complete);
				check_field("capturing", want.capturing, got.capturing);
			end
		end
	end

	always @(posedge clk)
		result_if.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[touch_calibration_dwell_capture_unit] ERROR");
		$finish;
	end

	initial begin : stimulus
		opening_row_t opening[25];
		int unsigned ph_cols[10]  = '{2, 31, 5, 16, 1, 16, 0, 0, 0, 7};
		int unsigned ph_rows[10]  = '{2, 16, 3, 16, 0, 2, 0, 31, 0, 4};
		int unsigned ph_dwell[10] = '{3, 1, 4, 2, 1, 65535, 0, 0, 0, 3};
		int unsigned ph_items[10] = '{150, 600, 200, 150, 100, 60, 200, 150, 200, 140};
		bit ph_rand[10] = '{0, 0, 0, 0, 0, 0, 1, 0, 1, 0};
		bit ph_tidy[10] = '{0, 1, 0, 0, 0, 0, 0, 0, 0, 0};
		bit ph_mid[10]  = '{1, 0, 1, 0, 0, 1, 1, 1, 1, 1};
		int unsigned target, halfway;
		bit held;

		arst_n = 1'b0;
		frame_if.valid = 1'b0;
		{frame_if.cmd, frame_if.blob_count, frame_if.touch_id, frame_if.touch_x,
			frame_if.touch_y} = '0;
		result_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_GRID_COLUMNS;
		cfg_if.data = '0;
		cal = '0;
		regs.grid_columns = GRID_RESET;
		regs.grid_rows = GRID_RESET;
		regs.dwell_frames = DWELL_RESET;
		held = 1'b0;

		opening[0]  = '{make_frame(CMD_FRAME, 1, 5, 100, 200), 1'b1, report(0, 0, 0, 0, 0, 0)};
		opening[1]  = '{make_frame(CMD_RESTART, 0, 0, 0, 0), 1'b1, report(0, 0, 0, 0, 0, 1)};
		opening[2]  = '{make_frame(CMD_FRAME, 0, 3, 1, 1), 1'b1, report(0, 0, 0, 0, 0, 1)};
		opening[3]  = '{make_frame(CMD_FRAME, 255, 3, 1, 1), 1'b1, report(0, 0, 0, 0, 0, 1)};
		opening[4]  = '{make_frame(CMD_FRAME, 2, 3, 1, 1), 1'b1, report(0, 0, 0, 0, 0, 1)};
		opening[5]  = '{make_frame(CMD_FRAME, 1, 0, 0, 0), 1'b1, report(0, 0, 0, 0, 0, 1)};
		opening[6]  = '{make_frame(CMD_FRAME, 1, 0, 16'hffff, 16'hffff), 1'b1,
			report(1, 0, 16'hffff, 16'hffff, 0, 1)};
		opening[7]  = '{make_frame(CMD_FRAME, 1, 0, 16'h1234, 16'h5678), 1'b1,
			report(0, 0, 0, 0, 0, 1)};
		opening[8]  = '{make_frame(CMD_FRAME, 1, 16'hffff, 16'h8000, 16'h7fff), 1'b0, '0};
		opening[9]  = '{make_frame(CMD_FRAME, 1, 16'hffff, 0, 16'hffff), 1'b0, '0};
		opening[10] = '{make_frame(CMD_FRAME, 1, 1, 16'haaaa, 16'h5555), 1'b0, '0};
		opening[11] = '{make_frame(CMD_FRAME, 1, 1, 16'h5555, 16'haaaa), 1'b0, '0};
		opening[12] = '{make_frame(CMD_RESTART, 1, 1, 0, 0), 1'b0, '0};
		opening[13] = '{make_frame(CMD_FRAME, 1, 1, 0, 0), 1'b0, '0};
		opening[14] = '{make_frame(CMD_FRAME, 1, 1, 9, 9), 1'b0, '0};
		opening[15] = '{make_frame(CMD_FRAME, 1, 7, 10, 20), 1'b0, '0};
		opening[16] = '{make_frame(CMD_FRAME, 1, 7, 30, 40), 1'b0, '0};
		opening[17] = '{make_frame(CMD_FRAME, 1, 8, 16'h4000, 16'hc000), 1'b0, '0};
		opening[18] = '{make_frame(CMD_FRAME, 1, 8, 16'hc000, 16'h4000), 1'b0, '0};
		opening[19] = '{make_frame(CMD_FRAME, 1, 9, 16'h0101, 16'hfefe), 1'b0, '0};
		opening[20] = '{make_frame(CMD_FRAME, 1, 9, 16'hfefe, 16'h0101), 1'b0, '0};
		opening[21] = '{make_frame(CMD_FRAME, 1, 10, 16'h0fff, 16'hf000), 1'b0, '0};
		opening[22] = '{make_frame(CMD_FRAME, 1, 10, 16'hf000, 16'h0fff), 1'b0, '0};
		opening[23] = '{make_frame(CMD_FRAME, 1, 10, 5, 5), 1'b1, report(0, 0, 0, 0, 1, 0)};
		opening[24] = '{make_frame(CMD_RESTART, 0, 0, 0, 0), 1'b1, report(0, 0, 0, 0, 1, 1)};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 2 x 2 grid through saturation, zero dwell acting as one
		write_config(0, 1, 0);
		foreach (opening[i])
			drive_frame(opening[i].frame, opening[i].typed, opening[i].reply);

		for (int p = 0; p < 10; p++) begin
			settle();
			if (ph_rand[p])
				write_config(GRID_BITS'($urandom_range(31)), GRID_BITS'($urandom_range(31)),
					DWELL_BITS'($urandom_range(6, 1)));
			else
				write_config(ph_cols[p], ph_rows[p], ph_dwell[p]);
			target = frames_sent + ph_items[p];
			halfway = frames_sent + ph_items[p] / 2;
			while (frames_sent < target) begin
				// hold the sender until the result channel has drained
				if (p == 2 && frames_sent >= halfway && !held) begin
					settle();
					held = 1'b1;
				end
				feed_run(ph_tidy[p], ph_mid[p]);
			end
		end
		settle();

		if (mismatches == 0)
			$display("[touch_calibration_dwell_capture_unit] OK");
		else
			$display("[touch_calibration_dwell_capture_unit] ERROR");
		$finish;
	end

endmodule
